@@ sv/r5rr_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, codes and types of the RAID5 read and rebuild engine.
package r5rr_pkg;

    localparam int DEF_MAX_DISKS      = 16;
    localparam int DEF_WORDS_PER_DISK = 1024;

    localparam int W_DISK = 4;
    localparam int W_WORD = 10;
    localparam int W_DATA = 32;
    localparam int W_BLK  = 20;
    localparam int W_N    = 5;
    localparam int W_S    = 11;
    localparam int W_LEN  = 11;
    localparam int W_PADDR = 4;
    localparam int W_PDATA = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_NUM_DISKS     = 2'd0;
    localparam logic [1:0] REG_STRIPE_BLOCKS = 2'd1;
    localparam logic [1:0] REG_DISK_WORDS    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_S,
        ST_DIV_N1,
        ST_DIV_N,
        ST_MUL,
        ST_ADD,
        ST_DECIDE,
        ST_WALK,
        ST_TAIL,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [W_N-1:0]   n;
        logic [W_S-1:0]   s;
        logic [W_LEN-1:0] len;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [W_BLK-1:0] dividend;
        logic [W_S-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [W_BLK-1:0] quot;
        logic [W_S-1:0]   rem;
    } div_rsp_t;

endpackage

@@ sv/r5rr_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module r5rr_ram
    import r5rr_pkg::*;
#(
    parameter int WIDTH = W_DATA,
    parameter int DEPTH = DEF_MAX_DISKS * DEF_WORDS_PER_DISK
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/r5rr_div.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring divider giving quotient and remainder, one bit a cycle.
module r5rr_div
    import r5rr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNW = $clog2(W_BLK);
    localparam logic [CNW-1:0] LAST_STEP = CNW'(W_BLK - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNW-1:0]   cnt_reg, cnt_next;
    logic [W_BLK-1:0] quo_reg, quo_next;
    logic [W_S-1:0]   rem_reg, rem_next;
    logic [W_S-1:0]   dvs_reg, dvs_next;
    logic [W_S:0]     shifted;
    logic [W_S:0]     diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[W_BLK-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[W_BLK-2:0], fits};
            rem_next = fits ? diff[W_S-1:0] : shifted[W_S-1:0];
            cnt_next = cnt_reg + CNW'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ sv/r5rr_cfg.sv @@
`timescale 1ns / 1ps
// APB register bank holding the array geometry and its saturated working values.
module r5rr_cfg
    import r5rr_pkg::*;
#(
    parameter int MAX_DISKS      = DEF_MAX_DISKS,
    parameter int WORDS_PER_DISK = DEF_WORDS_PER_DISK
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [W_PADDR-1:0] paddr,
    input  logic [W_PDATA-1:0] pwdata,
    output logic [W_PDATA-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [W_N-1:0]   num_disks_reg, num_disks_next;
    logic [W_S-1:0]   stripe_blocks_reg, stripe_blocks_next;
    logic [W_LEN-1:0] disk_words_reg, disk_words_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        num_disks_next     = num_disks_reg;
        stripe_blocks_next = stripe_blocks_reg;
        disk_words_next    = disk_words_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_NUM_DISKS:     num_disks_next     = pwdata[W_N-1:0];
                REG_STRIPE_BLOCKS: stripe_blocks_next = pwdata[W_S-1:0];
                REG_DISK_WORDS:    disk_words_next    = pwdata[W_LEN-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_disks_reg     <= W_N'(2);
            stripe_blocks_reg <= W_S'(1);
            disk_words_reg    <= '0;
        end
        else
        begin
            num_disks_reg     <= num_disks_next;
            stripe_blocks_reg <= stripe_blocks_next;
            disk_words_reg    <= disk_words_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_NUM_DISKS:     prdata = W_PDATA'(num_disks_reg);
            REG_STRIPE_BLOCKS: prdata = W_PDATA'(stripe_blocks_reg);
            REG_DISK_WORDS:    prdata = W_PDATA'(disk_words_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        if (num_disks_reg < W_N'(2))
        begin
            cfg.n = W_N'(2);
        end
        else if (32'(num_disks_reg) > MAX_DISKS)
        begin
            cfg.n = W_N'(MAX_DISKS);
        end
        else
        begin
            cfg.n = num_disks_reg;
        end
        cfg.s = (stripe_blocks_reg == '0) ? W_S'(1) : stripe_blocks_reg;
        if (32'(disk_words_reg) > WORDS_PER_DISK)
        begin
            cfg.len = W_LEN'(WORDS_PER_DISK);
        end
        else
        begin
            cfg.len = disk_words_reg;
        end
    end

endmodule

@@ sv/raid5_block_read_reconstruct.sv @@
`timescale 1ns / 1ps
// Top level of the RAID5 read engine with left-symmetric parity and XOR rebuild.
// Load words with indices in range write one 32-bit word into the disk store and
// mark the disk present; the next word is taken in the following cycle while the
// engine stays idle. A query word runs through one shared bit-serial divider three
// times (block by strip size, strip by n-1, row by n), then a multiply, an add, a
// decision, a store read and a hand-off to the output register; a query whose word
// lies beyond the disk skips the read. When the data disk is missing the word is
// rebuilt by reading the same word on every disk through the single read port of
// the store, one disk a cycle. A finished result waits in an output register, and
// a new word is accepted as soon as the engine has handed its result to that
// register.
module raid5_block_read_reconstruct
    import r5rr_pkg::*;
#(
    parameter int MAX_DISKS      = DEF_MAX_DISKS,
    parameter int WORDS_PER_DISK = DEF_WORDS_PER_DISK
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [W_PADDR-1:0] paddr,
    input  logic [W_PDATA-1:0] pwdata,
    output logic [W_PDATA-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [W_DISK-1:0]  disk_index,
    input  logic [W_WORD-1:0]  word_index,
    input  logic [W_DATA-1:0]  word_data,
    input  logic [W_BLK-1:0]   block_number,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               status,
    output logic [W_DATA-1:0]  block_data
);

    localparam int DKW   = $clog2(MAX_DISKS);
    localparam int DEPTH = MAX_DISKS * WORDS_PER_DISK;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = W_BLK + W_S;

    state_t state_reg, state_next;
    cfg_t   cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                 load_acc, query_acc, load_ok;
    logic [MAX_DISKS-1:0] present_reg, present_next;
    logic [W_S-1:0]       rems_reg, rems_next;
    logic [W_BLK-1:0]     row_reg, row_next;
    logic [W_BLK-1:0]     prod_reg, prod_next;
    logic [W_BLK-1:0]     off_reg, off_next;
    logic [W_N-1:0]       rank_reg, rank_next;
    logic [W_N-1:0]       rown_reg, rown_next;
    logic [W_N-1:0]       data_reg, data_next;
    logic [W_N-1:0]       i_reg, i_next;
    logic [W_DATA-1:0]    acc_reg, acc_next;
    logic                 miss_reg, miss_next;
    logic                 rv_reg, rv_next;
    logic                 res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_status_reg, out_status_next;
    logic [W_DATA-1:0]    out_data_reg, out_data_next;

    logic [PW-1:0]        prod_full;
    logic [W_N-1:0]       parity;
    logic [W_N:0]         data_sum;
    logic [W_N-1:0]       rd_disk;
    logic                 off_beyond, data_present, last_disk, out_free, out_load;
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [W_DATA-1:0]    ram_rdata;

    r5rr_cfg #(
        .MAX_DISKS      (MAX_DISKS),
        .WORDS_PER_DISK (WORDS_PER_DISK)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    r5rr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    r5rr_ram #(
        .WIDTH (W_DATA),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (word_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign load_acc  = in_valid && in_ready && (operation == OP_LOAD);
    assign query_acc = in_valid && in_ready && (operation == OP_QUERY);
    assign load_ok   = (32'(disk_index) < MAX_DISKS) && (32'(word_index) < WORDS_PER_DISK);

    assign ram_we    = load_acc && load_ok;
    assign ram_waddr = AW'(32'(disk_index) * WORDS_PER_DISK + 32'(word_index));

    assign prod_full    = PW'(row_reg) * PW'(cfg.s);
    assign parity       = cfg.n - W_N'(1) - rown_reg;
    assign data_sum     = (W_N + 1)'(parity) + (W_N + 1)'(1) + (W_N + 1)'(rank_reg);
    assign off_beyond   = off_reg >= W_BLK'(cfg.len);
    assign data_present = present_reg[DKW'(data_reg)];
    assign last_disk    = (i_reg == cfg.n - W_N'(1));
    assign rd_disk      = (state_reg == ST_DECIDE) ? data_reg : i_reg;
    assign ram_raddr    = AW'(32'(rd_disk) * WORDS_PER_DISK + 32'(off_reg));
    assign out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_acc)
                begin
                    state_next = ST_DIV_S;
                end
            end
            ST_DIV_S:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DIV_N1;
                end
            end
            ST_DIV_N1:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DIV_N;
                end
            end
            ST_DIV_N:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_ADD;
            ST_ADD:    state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (off_beyond)
                begin
                    state_next = ST_FIN;
                end
                else if (data_present)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (last_disk)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = div_rsp.quot;
        div_req.divisor  = cfg.s;
        ram_re           = 1'b0;
        rv_next          = 1'b0;
        out_load         = 1'b0;
        rems_next        = rems_reg;
        row_next         = row_reg;
        rank_next        = rank_reg;
        rown_next        = rown_reg;
        prod_next        = prod_reg;
        data_next        = data_reg;
        off_next         = off_reg;
        i_next           = i_reg;
        miss_next        = miss_reg;
        res_status_next  = res_status_reg;
        acc_next         = rv_reg ? (acc_reg ^ ram_rdata) : acc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                div_req.start    = query_acc;
                div_req.dividend = block_number;
                div_req.divisor  = cfg.s;
            end
            ST_DIV_S:
            begin
                div_req.start   = div_rsp.done;
                div_req.divisor = W_S'(cfg.n - W_N'(1));
                if (div_rsp.done)
                begin
                    rems_next = div_rsp.rem;
                end
            end
            ST_DIV_N1:
            begin
                div_req.start   = div_rsp.done;
                div_req.divisor = W_S'(cfg.n);
                if (div_rsp.done)
                begin
                    row_next  = div_rsp.quot;
                    rank_next = W_N'(div_rsp.rem);
                end
            end
            ST_DIV_N:
            begin
                if (div_rsp.done)
                begin
                    rown_next = W_N'(div_rsp.rem);
                end
            end
            ST_MUL:
            begin
                prod_next = prod_full[W_BLK-1:0];
                if (data_sum >= (W_N + 1)'(cfg.n))
                begin
                    data_next = W_N'(data_sum - (W_N + 1)'(cfg.n));
                end
                else
                begin
                    data_next = W_N'(data_sum);
                end
            end
            ST_ADD:
            begin
                off_next = prod_reg + W_BLK'(rems_reg);
            end
            ST_DECIDE:
            begin
                acc_next        = '0;
                miss_next       = 1'b0;
                i_next          = '0;
                res_status_next = off_beyond;
                ram_re          = !off_beyond && data_present;
                rv_next         = !off_beyond && data_present;
            end
            ST_WALK:
            begin
                ram_re  = 1'b1;
                rv_next = (i_reg != data_reg);
                i_next  = i_reg + W_N'(1);
                if ((i_reg != data_reg) && !present_reg[DKW'(i_reg)])
                begin
                    miss_next = 1'b1;
                end
            end
            ST_TAIL:
            begin
                res_status_next = miss_reg;
            end
            ST_FIN:
            begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        present_next = present_reg;
        if (ram_we)
        begin
            present_next[DKW'(disk_index)] = 1'b1;
        end
        out_valid_next  = out_load || (out_valid_reg && !out_ready);
        out_status_next = out_load ? res_status_reg : out_status_reg;
        out_data_next   = out_data_reg;
        if (out_load)
        begin
            out_data_next = res_status_reg ? '0 : acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            present_reg   <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rems_reg       <= rems_next;
        row_reg        <= row_next;
        rank_reg       <= rank_next;
        rown_reg       <= rown_next;
        prod_reg       <= prod_next;
        data_reg       <= data_next;
        off_reg        <= off_next;
        i_reg          <= i_next;
        acc_reg        <= acc_next;
        miss_reg       <= miss_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign block_data = out_data_reg;

endmodule

@@ sv/r5rr_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the RAID5 read engine, bound to the top level.
module r5rr_chk
    import r5rr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              operation,
    input logic              out_valid,
    input logic              out_ready,
    input logic              status,
    input logic [W_DATA-1:0] block_data
);

    // An unavailable result always carries a zero data word.
    a_unavail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (block_data == '0))
        else $error("Unavailable result carries non-zero data.");

    // A query keeps the engine busy for at least the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation == OP_QUERY)) |=> !in_ready)
        else $error("Engine ready directly after accepting a query.");

    // An idle engine with an empty output register cannot produce a result next cycle.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && !out_valid) |=> !out_valid)
        else $error("Result appeared without a query in progress.");

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(block_data)))
        else $error("Stalled result word changed.");

endmodule

bind raid5_block_read_reconstruct r5rr_chk u_r5rr_chk (.*);
